// File: rtl/date_day_of_year_converter_defines.svh
// Assertion macros shared by the day-of-year converter RTL.
`ifndef DATE_DAY_OF_YEAR_CONVERTER_DEFINES_SVH
`define DATE_DAY_OF_YEAR_CONVERTER_DEFINES_SVH

// Checked on every clock edge once reset is released.
`define DDOY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DDOY_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ddoy_pkg.sv
// Package: calendar tables, result type and constants for the day-of-year converter.
`default_nettype none
package ddoy_pkg;

  // Operation codes
  localparam logic OP_TO_ORDINAL = 1'b0;
  localparam logic OP_TO_DATE    = 1'b1;

  // floor(y / 25) == (y * Div25Mul) >> Div25Shift for every 16-bit y
  localparam int unsigned Div25Mul   = 83887;
  localparam int unsigned Div25Shift = 21;
  localparam int unsigned Div25QW    = 12;

  localparam int unsigned NumMonths = 12;

  typedef struct packed {
    logic       valid_res;
    logic [8:0] day_number_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
  } ddoy_res_t;

  // Length of month m (1..12); zero for codes that are no month
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m (1..12)
  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ddoy_calendar.sv
// Table lookup and range checks of both conversion directions, given the leap flag.
`default_nettype none
module ddoy_calendar (
  input  wire logic             operation,
  input  wire logic             leap,
  input  wire logic             year_nz,
  input  wire logic [3:0]       month,
  input  wire logic [4:0]       day,
  input  wire logic [8:0]       day_number,
  output ddoy_pkg::ddoy_res_t   res
);
  import ddoy_pkg::*;

  logic [4:0]  len_fwd;
  logic        ok_fwd;
  logic [8:0]  total;
  logic [8:0]  limit;
  logic        ok_inv;
  logic [NumMonths:1] fits;
  logic [3:0]  m_inv;
  logic [8:0]  rest;

  // Month/day to ordinal day
  always_comb begin
    len_fwd = month_len(leap, month);
    ok_fwd  = (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0) && (day <= len_fwd);
    total   = days_before(leap, month) + {4'b0, day};
  end

  // Ordinal day to month/day: compare against every month end, take the first that fits
  always_comb begin
    limit  = leap ? 9'd366 : 9'd365;
    ok_inv = year_nz && (day_number != 9'd0) && (day_number <= limit);
    for (int i = 1; i <= NumMonths; i++) begin
      fits[i] = day_number <= (days_before(leap, 4'(i)) + {4'b0, month_len(leap, 4'(i))});
    end
    m_inv = 4'd12;
    for (int i = NumMonths; i >= 1; i--) begin
      if (fits[i]) begin
        m_inv = 4'(i);
      end
    end
    rest = day_number - days_before(leap, m_inv);
  end

  // Result selection; invalid beats carry zero fields
  always_comb begin
    res = '0;
    if (operation == OP_TO_ORDINAL) begin
      if (ok_fwd) begin
        res.valid_res      = 1'b1;
        res.day_number_out = total;
      end
    end else begin
      if (ok_inv) begin
        res.valid_res = 1'b1;
        res.month_out = m_inv;
        res.day_out   = rest[4:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/date_day_of_year_converter.sv
// Top level: three-stage pipelined Gregorian month/day <-> ordinal day converter.
// Each input beat picks a direction with operation: 0 turns month and day into the
// ordinal day of the year, 1 turns an ordinal day back into month and day. Every
// beat yields one result beat, held in the stage three register; a new beat is taken
// every cycle while the output is not stalled. Stage one divides the year by 25 with a
// reciprocal multiply, stage two finishes the leap-year test, stage three does
// the month table lookups and range checks and holds the result. Invalid requests
// return valid_res low with all other fields zero. An output stall freezes only
// the stages that are full, so bubbles are squeezed out.
`default_nettype none
`include "date_day_of_year_converter_defines.svh"
module date_day_of_year_converter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic       operation,
  input  wire logic [15:0] year,
  input  wire logic [3:0] month,
  input  wire logic [4:0] day,
  input  wire logic [8:0] day_number,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       valid_res,
  output      logic [8:0] day_number_out,
  output      logic [3:0] month_out,
  output      logic [4:0] day_out
);
  import ddoy_pkg::*;

  // Stage valids and load enables
  logic v1, v2, v3;
  logic en1, en2, en3;

  // Stage 1 payload
  logic              s1_op;
  logic [15:0]       s1_year;
  logic [3:0]        s1_month;
  logic [4:0]        s1_day;
  logic [8:0]        s1_dn;
  logic [Div25QW-1:0] s1_q25;

  // Stage 2 payload
  logic        s2_op;
  logic        s2_leap;
  logic        s2_year_nz;
  logic [3:0]  s2_month;
  logic [4:0]  s2_day;
  logic [8:0]  s2_dn;

  // Stage 3 (output) payload
  ddoy_res_t   s3_res;
  ddoy_res_t   res_next;

  logic [32:0] prod25;
  logic [16:0] back25;
  logic        leap_next;

  // A stage loads when empty or when its contents move on
  always_comb begin
    en3 = !v3 || !out_stall;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
  end

  assign in_stall = !en1;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Stage 1: quotient of year by 25
  assign prod25 = {17'b0, year} * 33'(Div25Mul);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op    <= operation;
      s1_year  <= year;
      s1_month <= month;
      s1_day   <= day;
      s1_dn    <= day_number;
      s1_q25   <= prod25[Div25Shift +: Div25QW];
    end
  end

  // Stage 2: leap test; divisible by 25 means leap iff divisible by 16, else by 4
  always_comb begin
    back25    = {1'b0, s1_q25, 4'b0} + {2'b0, s1_q25, 3'b0} + {5'b0, s1_q25};
    leap_next = (back25 == {1'b0, s1_year}) ? (s1_year[3:0] == 4'd0)
                                             : (s1_year[1:0] == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op      <= s1_op;
      s2_leap    <= leap_next;
      s2_year_nz <= (s1_year != 16'd0);
      s2_month   <= s1_month;
      s2_day     <= s1_day;
      s2_dn      <= s1_dn;
    end
  end

  // Stage 3: conversion proper
  ddoy_calendar u_calendar (
    .operation  (s2_op),
    .leap       (s2_leap),
    .year_nz    (s2_year_nz),
    .month      (s2_month),
    .day        (s2_day),
    .day_number (s2_dn),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_res <= res_next;
    end
  end

  assign out_valid      = v3;
  assign valid_res      = s3_res.valid_res;
  assign day_number_out = s3_res.day_number_out;
  assign month_out      = s3_res.month_out;
  assign day_out        = s3_res.day_out;

  // Checks
  `DDOY_ASSERT(a_invalid_zero, out_valid && !valid_res |-> (day_number_out == 9'd0) && (month_out == 4'd0) && (day_out == 5'd0), "invalid result with nonzero fields")
  `DDOY_ASSERT(a_one_direction, out_valid && (day_number_out != 9'd0) |-> (month_out == 4'd0) && (day_out == 5'd0), "result carries both directions")
  `DDOY_ASSERT(a_date_sane, out_valid && valid_res && (month_out != 4'd0) |-> (day_out != 5'd0) && (month_out <= 4'd12), "bad month/day result")
  `DDOY_ASSERT(a_mid_hold, v2 && !en3 |=> v2, "stage two lost a beat while blocked")
  `DDOY_ASSERT_ALWAYS(a_empty_no_stall, !v1 |-> !in_stall, "input stalled with empty first stage")

endmodule
`default_nettype wire

// File: tb/date_day_of_year_converter_tb.sv
// Testbench for the day-of-year converter: directed and random beats checked against a predictor.
`default_nettype none
module date_day_of_year_converter_tb;
  import ddoy_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_TO_ORDINAL;
  logic [15:0] year = '0;
  logic [3:0]  month = '0;
  logic [4:0]  day = '0;
  logic [8:0]  day_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [8:0]  day_number_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;

  ddoy_res_t   pending_dates[$];
  ddoy_res_t   want;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          idle_en = 1'b1;

  date_day_of_year_converter i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .year           (year),
    .month          (month),
    .day            (day),
    .day_number     (day_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .valid_res      (valid_res),
    .day_number_out (day_number_out),
    .month_out      (month_out),
    .day_out        (day_out)
  );

  always #10 clk = ~clk;

  // Days in month m (1..12) of a leap or common year
  function automatic int unsigned days_of_month(input bit leap, input int unsigned m);
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Expected result of one conversion request
  function automatic ddoy_res_t convert_date(input logic op, input logic [15:0] yr,
                                             input logic [3:0] mo, input logic [4:0] dy,
                                             input logic [8:0] dn);
    ddoy_res_t   r;
    bit          leap;
    int unsigned acc;
    int unsigned m;
    r = '0;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (op == OP_TO_ORDINAL) begin
      if (mo >= 1 && mo <= NumMonths && dy >= 1 && dy <= days_of_month(leap, mo)) begin
        acc = dy;
        for (m = 1; m < mo; m++) acc += days_of_month(leap, m);
        r.valid_res = 1'b1;
        r.day_number_out = acc[8:0];
      end
    end else if (yr != 0 && dn != 0 && dn <= 365 + leap) begin
      acc = dn;
      m = 1;
      while (m <= NumMonths && acc > days_of_month(leap, m)) begin
        acc -= days_of_month(leap, m);
        m++;
      end
      r.valid_res = 1'b1;
      r.month_out = m[3:0];
      r.day_out = acc[4:0];
    end
    return r;
  endfunction

  // Drive one request beat, optionally after an idle burst; returns once accepted
  task automatic send_beat(input logic op, input logic [15:0] yr, input logic [3:0] mo,
                           input logic [4:0] dy, input logic [8:0] dn);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    year       <= yr;
    month      <= mo;
    day        <= dy;
    day_number <= dn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_dates.push_back(convert_date(op, yr, mo, dy, dn));
  endtask

  // Lower valid and wait until every pending result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Year biased toward the leap-rule corners
  function automatic logic [15:0] pick_year();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'($urandom_range(0, 163) * 400);
      2: return 16'($urandom_range(0, 655) * 100);
      3: return 16'($urandom_range(0, 16383) * 4);
      4: return 16'($urandom_range(1890, 2110));
      5: return 16'hffff - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // One random request, mostly near-valid with some raw noise
  task automatic random_beat();
    logic        op;
    logic [15:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [8:0]  dn;
    op = $urandom_range(0, 1) ? OP_TO_DATE : OP_TO_ORDINAL;
    yr = pick_year();
    mo = 4'($urandom);
    dy = 5'($urandom);
    dn = 9'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      if (op == OP_TO_ORDINAL) begin
        mo = 4'($urandom_range(1, NumMonths));
        dy = 5'($urandom_range(1, 31));
      end else begin
        dn = 9'($urandom_range(1, 367));
      end
    end
    send_beat(op, yr, mo, dy, dn);
  endtask

  // Month/day to ordinal: table ends, leap rules, bad month and bad day
  task automatic test_to_ordinal_directed();
    send_beat(OP_TO_ORDINAL, 16'd2023, 4'd1, 5'd1, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd2023, 4'd12, 5'd31, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd2024, 4'd12, 5'd31, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd2024, 4'd2, 5'd29, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd2023, 4'd2, 5'd29, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd1900, 4'd2, 5'd29, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd2000, 4'd3, 5'd1, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd0, 4'd2, 5'd29, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd2023, 4'd0, 5'd10, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd2023, 4'd13, 5'd10, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'hffff, 4'd15, 5'd31, 9'h1ff);
    send_beat(OP_TO_ORDINAL, 16'd2023, 4'd6, 5'd0, 9'($urandom));
    send_beat(OP_TO_ORDINAL, 16'd2023, 4'd4, 5'd31, 9'($urandom));
  endtask

  // Ordinal to month/day: first and last day, year zero, out-of-range day numbers
  task automatic test_to_date_directed();
    send_beat(OP_TO_DATE, 16'd2023, 4'($urandom), 5'($urandom), 9'd1);
    send_beat(OP_TO_DATE, 16'd2023, 4'($urandom), 5'($urandom), 9'd365);
    send_beat(OP_TO_DATE, 16'd2023, 4'($urandom), 5'($urandom), 9'd366);
    send_beat(OP_TO_DATE, 16'd2024, 4'($urandom), 5'($urandom), 9'd366);
    send_beat(OP_TO_DATE, 16'd2024, 4'($urandom), 5'($urandom), 9'd60);
    send_beat(OP_TO_DATE, 16'd2100, 4'($urandom), 5'($urandom), 9'd60);
    send_beat(OP_TO_DATE, 16'd2023, 4'($urandom), 5'($urandom), 9'd0);
    send_beat(OP_TO_DATE, 16'd0, 4'($urandom), 5'($urandom), 9'd100);
    send_beat(OP_TO_DATE, 16'd2023, 4'($urandom), 5'($urandom), 9'h1ff);
    send_beat(OP_TO_DATE, 16'hffff, 4'($urandom), 5'($urandom), 9'd59);
  endtask

  // Random mix with idling on both sides
  task automatic test_random_mix(input int unsigned n);
    repeat (n) random_beat();
  endtask

  // Sender holds off until the pipeline is empty, then resumes
  task automatic test_hold_off(input int unsigned n);
    repeat (n) random_beat();
    wait_drained();
    repeat (n) random_beat();
  endtask

  // Back-to-back beats with no idling at all
  task automatic test_full_rate(input int unsigned n);
    idle_en = 1'b0;
    repeat (n) random_beat();
  endtask

  // Receiver stall bursts
  always @(posedge clk) begin
    if (rst || !idle_en) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $error("result beat with no pending request");
        fail_cnt++;
      end else begin
        want = pending_dates.pop_front();
        if (valid_res !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, valid_res);
          fail_cnt++;
        end
        if (day_number_out !== want.day_number_out) begin
          $error("day_number_out: expected %0d, got %0d", want.day_number_out, day_number_out);
          fail_cnt++;
        end
        if (month_out !== want.month_out) begin
          $error("month_out: expected %0d, got %0d", want.month_out, month_out);
          fail_cnt++;
        end
        if (day_out !== want.day_out) begin
          $error("day_out: expected %0d, got %0d", want.day_out, day_out);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_to_ordinal_directed();
    test_to_date_directed();
    test_random_mix(700);
    test_hold_off(60);
    test_full_rate(330);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (pending_dates.size() != 0) begin
      $error("%0d results never arrived", pending_dates.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
